/* sv/lmrs_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmrs_pkg
// Shared types and constants of the LED matrix row scanner.
// ----------------------------------------------------------------------------
package lmrs_pkg;

	localparam int NUM_COLUMNS_DEF = 64;
	localparam int NUM_ROWS_DEF    = 7;
	localparam int ADDR_MAX_W      = 12;
	localparam int ROW_ENABLE_W    = 7;
	localparam int ONE_HOT_W       = 16;
	localparam int TICKS_W         = 16;
	localparam int PADDR_W         = 3;

	localparam logic [TICKS_W-1:0] ROW_ON_TICKS_RST = 16'd100;
	localparam logic               REG_ROW_ON_TICKS = 1'b0;

	localparam logic ACT_WRITE = 1'b0;
	localparam logic ACT_TICK  = 1'b1;

	typedef enum logic [1:0] {
		PH_DATA  = 2'd0,
		PH_CLOCK = 2'd1,
		PH_ON    = 2'd2
	} phase_t;

	typedef struct packed {
		logic                  is_tick;
		logic [ADDR_MAX_W-1:0] addr;
		logic                  value;
	} entry_t;

endpackage

/* sv/led_matrix_row_scanner_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_matrix_row_scanner_unit
// Row-multiplexed LED matrix scan driver with a one-bit frame store.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready): action 0 writes pixel_value into the
// frame store at pixel_row/pixel_col (out-of-range writes are dropped) and
// produces no output word; action 1 is one scan tick and produces exactly one
// output word with serial_data, shift_clock, row_enable and frame_end.
// Output channel (out_valid/out_ready) carries those words in order.
// A tick passes through the two-entry queue and then the output register.
// Throughput: one word per cycle while the receiver keeps up, set by the
// single-port frame store (one pixel write or one pixel read per cycle) behind a two-entry queue.
// APB register 0 (byte address 0): row_on_ticks, reset 100, 0 acts as 1.
// Reset: after arst_n releases, the frame store is cleared one pixel per
// cycle, NUM_ROWS*NUM_COLUMNS pixels (448 by default); in_ready stays low
// meanwhile. APB writes are taken at any time.
// Receiver stall: the output register holds its word; the queue absorbs up
// to two more words, then in_ready drops. Head pixel writes keep draining.
// ----------------------------------------------------------------------------
module led_matrix_row_scanner_unit
	import lmrs_pkg::*;
#(
	parameter int NUM_COLUMNS = NUM_COLUMNS_DEF,
	parameter int NUM_ROWS    = NUM_ROWS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [PADDR_W-1:0]      paddr,
	input  logic [31:0]             pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    action,
	input  logic [2:0]              pixel_row,
	input  logic [5:0]              pixel_col,
	input  logic                    pixel_value,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    serial_data,
	output logic                    shift_clock,
	output logic [ROW_ENABLE_W-1:0] row_enable,
	output logic                    frame_end
);

	logic [TICKS_W-1:0] row_on_ticks_q;
	logic               reg_sel;
	logic               busy;
	logic               q_valid;
	logic               q_pop;
	entry_t             q_entry;

	assign pready  = 1'b1;
	assign reg_sel = (paddr[PADDR_W-1] == REG_ROW_ON_TICKS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_on_ticks_q <= ROW_ON_TICKS_RST;
		end else if (psel && penable && pwrite && reg_sel) begin
			row_on_ticks_q <= pwdata[TICKS_W-1:0];
		end
	end

	assign prdata = reg_sel ? {{(32 - TICKS_W){1'b0}}, row_on_ticks_q} : '0;

	lmrs_front #(
		.NUM_COLUMNS(NUM_COLUMNS),
		.NUM_ROWS(NUM_ROWS)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.hold(busy),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.action(action),
		.pixel_row(pixel_row),
		.pixel_col(pixel_col),
		.pixel_value(pixel_value),
		.q_valid(q_valid),
		.q_entry(q_entry),
		.q_pop(q_pop)
	);

	lmrs_back #(
		.NUM_COLUMNS(NUM_COLUMNS),
		.NUM_ROWS(NUM_ROWS)
	) u_back (
		.clk(clk),
		.arst_n(arst_n),
		.row_on_ticks(row_on_ticks_q),
		.q_valid(q_valid),
		.q_entry(q_entry),
		.q_pop(q_pop),
		.busy(busy),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.serial_data(serial_data),
		.shift_clock(shift_clock),
		.row_enable(row_enable),
		.frame_end(frame_end)
	);

endmodule

/* sv/lmrs_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmrs_front
// Accepts words, decodes pixel writes to a store address, drops out-of-range
// writes and queues the rest in a two-entry queue for the scan engine.
// ----------------------------------------------------------------------------
module lmrs_front
	import lmrs_pkg::*;
#(
	parameter int NUM_COLUMNS = NUM_COLUMNS_DEF,
	parameter int NUM_ROWS    = NUM_ROWS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       hold,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic       action,
	input  logic [2:0] pixel_row,
	input  logic [5:0] pixel_col,
	input  logic       pixel_value,
	output logic       q_valid,
	output entry_t     q_entry,
	input  logic       q_pop
);

	entry_t     slot_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       accept;
	logic       in_range;
	logic       push;
	entry_t     entry_c;

	assign in_ready = (count_q != 2'd2) && !hold;
	assign accept   = in_valid && in_ready;
	assign in_range = (int'(pixel_row) < NUM_ROWS) && (int'(pixel_col) < NUM_COLUMNS);
	assign push     = accept && ((action == ACT_TICK) || in_range);

	always_comb begin
		entry_c.is_tick = (action == ACT_TICK);
		entry_c.addr    = ADDR_MAX_W'(int'(pixel_row) * NUM_COLUMNS + int'(pixel_col));
		entry_c.value   = pixel_value;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= entry_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(q_pop);
		end
	end

	assign q_valid = (count_q != 2'd0);
	assign q_entry = slot_q[rd_ptr_q];

endmodule

/* sv/lmrs_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lmrs_back
// Scan engine: frame store memory, scan sequencer and output register.
// Clears the frame store one pixel per cycle after reset.
// ----------------------------------------------------------------------------
module lmrs_back
	import lmrs_pkg::*;
#(
	parameter int NUM_COLUMNS = NUM_COLUMNS_DEF,
	parameter int NUM_ROWS    = NUM_ROWS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [TICKS_W-1:0]      row_on_ticks,
	input  logic                    q_valid,
	input  entry_t                  q_entry,
	output logic                    q_pop,
	output logic                    busy,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic                    serial_data,
	output logic                    shift_clock,
	output logic [ROW_ENABLE_W-1:0] row_enable,
	output logic                    frame_end
);

	localparam int DEPTH  = NUM_ROWS * NUM_COLUMNS;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int ROW_W  = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
	localparam int COL_W  = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;

	logic                    mem [DEPTH];
	logic                    mem_we;
	logic [ADDR_W-1:0]       mem_waddr;
	logic                    mem_wdata;
	logic [ADDR_W-1:0]       rd_addr;

	logic                    clr_busy_q;
	logic [ADDR_W-1:0]       clr_cnt_q;

	phase_t                  phase_q, phase_d;
	logic [ROW_W-1:0]        row_q, row_d;
	logic [COL_W-1:0]        col_q, col_d;
	logic [TICKS_W-1:0]      dwell_q, dwell_d;
	logic [TICKS_W-1:0]      dwell_inc;
	logic [TICKS_W-1:0]      limit;
	logic                    row_done;
	logic                    row_last;
	logic [ONE_HOT_W-1:0]    row_oh;

	logic [COL_W-1:0]        rd_col;
	logic                    clk_c;
	logic [ROW_ENABLE_W-1:0] rows_c;
	logic                    fend_c;

	logic                    adv;
	logic                    tick;
	logic                    valid_s1;
	logic                    data_s1;
	logic                    clk_s1;
	logic [ROW_ENABLE_W-1:0] rows_s1;
	logic                    fend_s1;

	assign busy  = clr_busy_q;
	assign adv   = !valid_s1 || out_ready;
	assign q_pop = q_valid && !clr_busy_q && (!q_entry.is_tick || adv);
	assign tick  = q_pop && q_entry.is_tick;

	assign limit     = (row_on_ticks == '0) ? TICKS_W'(1) : row_on_ticks;
	assign dwell_inc = dwell_q + TICKS_W'(1);
	assign row_done  = (dwell_inc >= limit);
	assign row_last  = (int'(row_q) == NUM_ROWS - 1);
	assign row_oh    = ONE_HOT_W'(1) << row_q;

	// next state
	always_comb begin
		phase_d = phase_q;
		row_d   = row_q;
		col_d   = col_q;
		dwell_d = dwell_q;
		case (phase_q)
			PH_CLOCK: begin
				if (col_q == '0) begin
					phase_d = PH_ON;
					dwell_d = '0;
				end else begin
					col_d   = col_q - COL_W'(1);
					phase_d = PH_DATA;
				end
			end
			PH_ON: begin
				if (row_done) begin
					row_d   = row_last ? '0 : row_q + ROW_W'(1);
					col_d   = COL_W'(NUM_COLUMNS - 1);
					phase_d = PH_DATA;
					dwell_d = '0;
				end else begin
					dwell_d = dwell_inc;
				end
			end
			default: begin
				phase_d = PH_CLOCK;
			end
		endcase
	end

	// outputs
	always_comb begin
		rd_col = col_q;
		clk_c  = 1'b0;
		rows_c = '0;
		fend_c = 1'b0;
		case (phase_q)
			PH_CLOCK: begin
				clk_c = 1'b1;
			end
			PH_ON: begin
				rd_col = '0;
				rows_c = row_oh[ROW_ENABLE_W-1:0];
				fend_c = row_done && row_last;
			end
			default: begin
				rd_col = col_q;
			end
		endcase
	end

	assign rd_addr = ADDR_W'((NUM_ROWS - 1 - int'(row_q)) * NUM_COLUMNS + int'(rd_col));

	always_comb begin
		if (clr_busy_q) begin
			mem_we    = 1'b1;
			mem_waddr = clr_cnt_q;
			mem_wdata = 1'b0;
		end else begin
			mem_we    = q_pop && !q_entry.is_tick;
			mem_waddr = q_entry.addr[ADDR_W-1:0];
			mem_wdata = q_entry.value;
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (tick) begin
			data_s1 <= mem[rd_addr];
			clk_s1  <= clk_c;
			rows_s1 <= rows_c;
			fend_s1 <= fend_c;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_busy_q <= 1'b1;
			clr_cnt_q  <= '0;
			phase_q    <= PH_DATA;
			row_q      <= '0;
			col_q      <= COL_W'(NUM_COLUMNS - 1);
			dwell_q    <= '0;
			valid_s1   <= 1'b0;
		end else begin
			if (clr_busy_q) begin
				clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
				if (int'(clr_cnt_q) == DEPTH - 1) begin
					clr_busy_q <= 1'b0;
				end
			end
			if (tick) begin
				phase_q <= phase_d;
				row_q   <= row_d;
				col_q   <= col_d;
				dwell_q <= dwell_d;
			end
			if (adv) begin
				valid_s1 <= tick;
			end
		end
	end

	assign out_valid   = valid_s1;
	assign serial_data = data_s1;
	assign shift_clock = clk_s1;
	assign row_enable  = rows_s1;
	assign frame_end   = fend_s1;

	a_no_pop_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clr_busy_q |-> !q_pop)
		else $error("queue popped during frame store clear");

	a_dwell_only_on: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_ON) |-> (dwell_q == '0))
		else $error("dwell count nonzero outside row on phase");

	a_clock_not_on: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> !(clk_s1 && (rows_s1 != '0)))
		else $error("shift clock high while a row is enabled");

	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(tick && fend_c) |=> (row_q == '0) && (phase_q == PH_DATA))
		else $error("frame end without scan wrap");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(int'(row_q) < NUM_ROWS) && (int'(col_q) < NUM_COLUMNS))
		else $error("scan position out of range");

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the LED matrix row scanner.
// ----------------------------------------------------------------------------
// Pixel writes and scan ticks go in over the input handshake. A scoreboard
// keeps its own frame store and scan position. For every accepted tick it
// works out the pin state and compares it with the next output word, in
// order. The row dwell time is reprogrammed over APB between phases while
// the block is idle, and read back. The phases run under different
// sender/receiver stall mixes. The scan position carries across phases.
// ----------------------------------------------------------------------------
import lmrs_pkg::*;

typedef struct packed {
	logic                    serial_data;
	logic                    shift_clock;
	logic [ROW_ENABLE_W-1:0] row_enable;
	logic                    frame_end;
} pin_state_t;

class scan_scoreboard;
	bit                 pixels [NUM_ROWS_DEF][NUM_COLUMNS_DEF];
	logic [2:0]         scan_row;
	logic [5:0]         scan_col;
	phase_t             phase;
	logic [TICKS_W-1:0] dwell;
	logic [TICKS_W-1:0] on_ticks;
	pin_state_t         expected_pins [$];
	int unsigned        failures;
	int unsigned        writes;
	int unsigned        ticks;
	int unsigned        checked;
	int unsigned        frame_ends;

	function new();
		foreach (pixels[r, c]) pixels[r][c] = 1'b0;
		scan_row   = '0;
		scan_col   = 6'(NUM_COLUMNS_DEF - 1);
		phase      = PH_DATA;
		dwell      = '0;
		on_ticks   = ROW_ON_TICKS_RST;
		failures   = 0;
		writes     = 0;
		ticks      = 0;
		checked    = 0;
		frame_ends = 0;
	endfunction

	function void set_on_ticks(logic [TICKS_W-1:0] v);
		on_ticks = v;
	endfunction

	function int pending();
		return expected_pins.size();
	endfunction

	function bit pixel_of(logic [2:0] r, logic [5:0] c);
		return pixels[NUM_ROWS_DEF - 1 - int'(r)][int'(c)];
	endfunction

	function void fail(string msg);
		failures++;
		if (failures <= 10)
			$display("MISMATCH: %s", msg);
	endfunction

	// updates the frame store for one accepted pixel write, or predicts the pin state of one accepted tick
	function void predict_scan_word(logic act, logic [2:0] r, logic [5:0] c, logic v);
		pin_state_t         e;
		logic [TICKS_W-1:0] limit;
		if (act == ACT_WRITE) begin
			writes++;
			if (int'(r) < NUM_ROWS_DEF && int'(c) < NUM_COLUMNS_DEF)
				pixels[r][c] = v;
			return;
		end
		ticks++;
		e = '0;
		case (phase)
			PH_CLOCK: begin
				e.serial_data = pixel_of(scan_row, scan_col);
				e.shift_clock = 1'b1;
				if (scan_col == 0) begin
					phase = PH_ON;
					dwell = '0;
				end else begin
					scan_col = scan_col - 1'b1;
					phase    = PH_DATA;
				end
			end
			PH_ON: begin
				limit        = (on_ticks == 0) ? TICKS_W'(1) : on_ticks;
				e.serial_data = pixel_of(scan_row, 6'd0);
				e.row_enable  = ROW_ENABLE_W'(1) << scan_row;
				dwell         = dwell + 1'b1;
				if (dwell >= limit) begin
					if (int'(scan_row) + 1 >= NUM_ROWS_DEF) begin
						e.frame_end = 1'b1;
						scan_row    = '0;
					end else begin
						scan_row = scan_row + 1'b1;
					end
					scan_col = 6'(NUM_COLUMNS_DEF - 1);
					phase    = PH_DATA;
					dwell    = '0;
				end
			end
			default: begin
				e.serial_data = pixel_of(scan_row, scan_col);
				phase         = PH_CLOCK;
			end
		endcase
		expected_pins.push_back(e);
	endfunction

	function void check_scan_word(pin_state_t got);
		pin_state_t e;
		if (expected_pins.size() == 0) begin
			fail($sformatf("unexpected word data=%0b clk=%0b rows=%02h fend=%0b",
				got.serial_data, got.shift_clock, got.row_enable, got.frame_end));
			return;
		end
		e = expected_pins.pop_front();
		checked++;
		if (e.frame_end)
			frame_ends++;
		if (got.serial_data !== e.serial_data)
			fail($sformatf("word %0d serial_data exp %0b got %0b",
				checked, e.serial_data, got.serial_data));
		if (got.shift_clock !== e.shift_clock)
			fail($sformatf("word %0d shift_clock exp %0b got %0b",
				checked, e.shift_clock, got.shift_clock));
		if (got.row_enable !== e.row_enable)
			fail($sformatf("word %0d row_enable exp %02h got %02h",
				checked, e.row_enable, got.row_enable));
		if (got.frame_end !== e.frame_end)
			fail($sformatf("word %0d frame_end exp %0b got %0b",
				checked, e.frame_end, got.frame_end));
	endfunction
endclass

module testbench;

	localparam int          CLK_HALF      = 10;
	localparam int          PHASES        = 6;
	localparam int          PHASE_WORDS   = 100;
	localparam int          DRAIN_CYCLES  = 8;
	localparam int unsigned CYCLE_LIMIT   = 400000;
	localparam logic [PADDR_W-1:0] ADDR_ROW_ON_TICKS = PADDR_W'(4 * REG_ROW_ON_TICKS);
	localparam logic [PADDR_W-1:0] ADDR_SPARE        = PADDR_W'(4);

	logic                    clk         = 1'b0;
	logic                    arst_n      = 1'b0;
	logic                    psel        = 1'b0;
	logic                    penable     = 1'b0;
	logic                    pwrite      = 1'b0;
	logic [PADDR_W-1:0]      paddr       = '0;
	logic [31:0]             pwdata      = '0;
	logic [31:0]             prdata;
	logic                    pready;
	logic                    in_valid    = 1'b0;
	logic                    in_ready;
	logic                    action      = ACT_WRITE;
	logic [2:0]              pixel_row   = '0;
	logic [5:0]              pixel_col   = '0;
	logic                    pixel_value = 1'b0;
	logic                    out_valid;
	logic                    out_ready   = 1'b0;
	logic                    serial_data;
	logic                    shift_clock;
	logic [ROW_ENABLE_W-1:0] row_enable;
	logic                    frame_end;

	scan_scoreboard          sb;
	int unsigned             cycles      = 0;
	int                      tx_idle     = 0;
	int                      rx_idle     = 0;
	int unsigned             settings    = 0;
	logic [TICKS_W-1:0]      on_values [PHASES] = '{16'd1, 16'd0, 16'd2, 16'd65535, 16'd1, 16'd3};

	led_matrix_row_scanner_unit u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.action      (action),
		.pixel_row   (pixel_row),
		.pixel_col   (pixel_col),
		.pixel_value (pixel_value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.serial_data (serial_data),
		.shift_clock (shift_clock),
		.row_enable  (row_enable),
		.frame_end   (frame_end)
	);

	always #(CLK_HALF) clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= rx_idle);
	end

	always @(posedge clk) begin
		if (arst_n && sb != null) begin
			if (in_valid && in_ready)
				sb.predict_scan_word(action, pixel_row, pixel_col, pixel_value);
			if (out_valid && out_ready)
				sb.check_scan_word('{serial_data, shift_clock, row_enable, frame_end});
		end
	end

	task automatic apb_access(input logic wr, input logic [PADDR_W-1:0] a,
			input logic [31:0] d, output logic [31:0] rd);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= a;
		pwdata  <= d;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rd      = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic program_on_ticks(input logic [PADDR_W-1:0] a, input logic [TICKS_W-1:0] v);
		logic [31:0] rd;
		apb_access(1'b1, a, {16'($urandom()), v}, rd);
		if (a == ADDR_ROW_ON_TICKS) begin
			sb.set_on_ticks(v);
			settings++;
		end
		@(posedge clk);
		apb_access(1'b0, ADDR_ROW_ON_TICKS, '0, rd);
		if (rd[TICKS_W-1:0] !== sb.on_ticks)
			sb.fail($sformatf("row_on_ticks readback exp %0d got %0d",
				sb.on_ticks, rd[TICKS_W-1:0]));
	endtask

	task automatic send_word(input logic act, input logic [2:0] r, input logic [5:0] c,
			input logic v);
		in_valid    <= 1'b1;
		action      <= act;
		pixel_row   <= r;
		pixel_col   <= c;
		pixel_value <= v;
		do @(posedge clk); while (!in_ready);
		while ($urandom_range(0, 99) < tx_idle) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic send_random_word();
		if ($urandom_range(0, 99) < 10)
			send_word(ACT_WRITE, 3'($urandom_range(0, 7)), 6'($urandom()), 1'($urandom()));
		else
			send_word(ACT_TICK, 3'($urandom()), 6'($urandom()), 1'($urandom()));
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	initial begin
		sb = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// spare address must leave the dwell register at its reset value
		program_on_ticks(ADDR_SPARE, 16'd7);

		send_word(ACT_WRITE, 3'd6, 6'd63, 1'b1);
		send_word(ACT_WRITE, 3'd6, 6'd61, 1'b1);
		send_word(ACT_WRITE, 3'd6, 6'd0,  1'b1);
		send_word(ACT_WRITE, 3'd0, 6'd0,  1'b1);
		send_word(ACT_WRITE, 3'd7, 6'd62, 1'b1);
		send_word(ACT_WRITE, 3'd7, 6'd0,  1'b1);
		send_word(ACT_WRITE, 3'd6, 6'd61, 1'b0);
		send_word(ACT_WRITE, 3'd3, 6'd33, 1'b1);
		repeat (12) send_word(ACT_TICK, 3'd7, 6'd63, 1'b1);
		send_word(ACT_TICK, 3'd0, 6'd0, 1'b0);
		wait_idle();

		for (int p = 0; p < PHASES; p++) begin
			case (p / 2)
				0: begin tx_idle = 10; rx_idle = 76; end
				1: begin tx_idle = 76; rx_idle = 10; end
				default: begin tx_idle = 0; rx_idle = 0; end
			endcase
			program_on_ticks(ADDR_ROW_ON_TICKS, on_values[p]);
			repeat (PHASE_WORDS) send_random_word();
			wait_idle();
		end

		tx_idle = 0;
		rx_idle = 0;
		wait_idle();
		repeat (20) @(posedge clk);

		$display("Ran %0d pixel writes and %0d scan ticks over %0d dwell settings",
			sb.writes, sb.ticks, settings);
		$display("Checked %0d output words, %0d frame ends, in %0d cycles",
			sb.checked, sb.frame_ends, cycles);
		if (sb.failures == 0 && sb.pending() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("%0d failures, %0d words still expected", sb.failures, sb.pending());
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
